// File: rtl/bmt_pkg.sv
// Shared types, constants and face tables for the box mesh tessellator.
// No dependencies; every other file of the block imports this package.
package bmt_pkg;

  // Clamp limit for segment counts and number of significant extent bits.
  localparam int SEG_MAX  = 255;
  localparam int DIM_BITS = 16;

  // Field widths.
  localparam int DIM_W     = 16;
  localparam int SEG_W     = 8;
  localparam int CFG_IDX_W = 3;
  localparam int POS_W     = 17;
  localparam int TEX_W     = 17;
  localparam int IDX_W     = 19;
  localparam int NORM_W    = 3;
  localparam int FACE_W    = 3;
  localparam int AXIS_W    = 2;

  // Divider geometry: 28-bit dividend, four quotient bits per cycle.
  localparam int DIVIDEND_W = 28;
  localparam int DIGIT_BITS = 4;
  localparam int QUOT_STEPS = DIVIDEND_W / DIGIT_BITS;
  localparam int STEP_CNT_W = $clog2(QUOT_STEPS);

  // Index of the final face of the mesh.
  localparam logic [FACE_W-1:0] FACE_LAST = 3'd5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BOX_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_DEPTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEG_ACROSS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEG_UP     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SEG_DEEP   = 3'd5;

  // Axis codes.
  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  // Normal codes.
  localparam logic [NORM_W-1:0] NORM_POS_X = 3'd0;
  localparam logic [NORM_W-1:0] NORM_NEG_X = 3'd1;
  localparam logic [NORM_W-1:0] NORM_POS_Y = 3'd2;
  localparam logic [NORM_W-1:0] NORM_NEG_Y = 3'd3;
  localparam logic [NORM_W-1:0] NORM_POS_Z = 3'd4;
  localparam logic [NORM_W-1:0] NORM_NEG_Z = 3'd5;

  // Effective configuration: extents masked, segment counts clamped.
  typedef struct packed {
    logic [DIM_W-1:0] dim_w;
    logic [DIM_W-1:0] dim_h;
    logic [DIM_W-1:0] dim_d;
    logic [SEG_W-1:0] seg_a;
    logic [SEG_W-1:0] seg_u;
    logic [SEG_W-1:0] seg_d;
  } bmt_cfg_t;

  // A count of zero acts as one; counts above the limit are clamped.
  function automatic logic [SEG_W-1:0] seg_fix(input logic [SEG_W-1:0] s);
    logic [SEG_W-1:0] r;
    r = s;
    if (s == '0) begin
      r = SEG_W'(1);
    end else if (int'(s) > SEG_MAX) begin
      r = SEG_W'(SEG_MAX);
    end
    return r;
  endfunction

  // Face table. Codes six and seven never occur and fall back to face zero.
  function automatic logic [AXIS_W-1:0] face_u_axis(input logic [FACE_W-1:0] f);
    logic [AXIS_W-1:0] r;
    unique case (f)
      3'd4, 3'd5: r = AXIS_Z;
      default:    r = AXIS_X;
    endcase
    return r;
  endfunction

  function automatic logic [AXIS_W-1:0] face_v_axis(input logic [FACE_W-1:0] f);
    logic [AXIS_W-1:0] r;
    unique case (f)
      3'd2, 3'd3: r = AXIS_Z;
      default:    r = AXIS_Y;
    endcase
    return r;
  endfunction

  function automatic logic [AXIS_W-1:0] face_w_axis(input logic [FACE_W-1:0] f);
    logic [AXIS_W-1:0] r;
    unique case (f)
      3'd2, 3'd3: r = AXIS_Y;
      3'd4, 3'd5: r = AXIS_X;
      default:    r = AXIS_Z;
    endcase
    return r;
  endfunction

  function automatic logic face_u_neg(input logic [FACE_W-1:0] f);
    return (f == 3'd1) || (f == 3'd4);
  endfunction

  function automatic logic face_v_neg(input logic [FACE_W-1:0] f);
    return (f != 3'd2);
  endfunction

  function automatic logic face_w_neg(input logic [FACE_W-1:0] f);
    return (f == 3'd1) || (f == 3'd3) || (f == 3'd5);
  endfunction

  function automatic logic [NORM_W-1:0] face_normal(input logic [FACE_W-1:0] f);
    logic [NORM_W-1:0] r;
    unique case (f)
      3'd1:    r = NORM_NEG_Z;
      3'd2:    r = NORM_POS_Y;
      3'd3:    r = NORM_NEG_Y;
      3'd4:    r = NORM_POS_X;
      3'd5:    r = NORM_NEG_X;
      default: r = NORM_POS_Z;
    endcase
    return r;
  endfunction

  // Extent and segment count that belong to an axis.
  function automatic logic [DIM_W-1:0] dim_of_axis(input bmt_cfg_t c,
                                                   input logic [AXIS_W-1:0] a);
    logic [DIM_W-1:0] r;
    unique case (a)
      AXIS_X:  r = c.dim_w;
      AXIS_Y:  r = c.dim_h;
      default: r = c.dim_d;
    endcase
    return r;
  endfunction

  function automatic logic [SEG_W-1:0] seg_of_axis(input bmt_cfg_t c,
                                                   input logic [AXIS_W-1:0] a);
    logic [SEG_W-1:0] r;
    unique case (a)
      AXIS_X:  r = c.seg_a;
      AXIS_Y:  r = c.seg_u;
      default: r = c.seg_d;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/bmt_config_regs.sv
// Configuration register file of the box mesh tessellator.
// Depends on bmt_pkg for register indexes, widths and the bmt_cfg_t struct.
module bmt_config_regs import bmt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  output bmt_cfg_t             cfg
);

  localparam logic [DIM_W-1:0] DIM_MASK =
    (DIM_BITS >= DIM_W) ? {DIM_W{1'b1}} : DIM_W'((1 << DIM_BITS) - 1);

  logic [DIM_W-1:0] box_width;
  logic [DIM_W-1:0] box_height;
  logic [DIM_W-1:0] box_depth;
  logic [SEG_W-1:0] seg_across;
  logic [SEG_W-1:0] seg_up;
  logic [SEG_W-1:0] seg_deep;

  // Register writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      box_width  <= 16'd256;
      box_height <= 16'd256;
      box_depth  <= 16'd256;
      seg_across <= 8'd1;
      seg_up     <= 8'd1;
      seg_deep   <= 8'd1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BOX_WIDTH:  box_width  <= cfg_data;
        REG_BOX_HEIGHT: box_height <= cfg_data;
        REG_BOX_DEPTH:  box_depth  <= cfg_data;
        REG_SEG_ACROSS: seg_across <= cfg_data[SEG_W-1:0];
        REG_SEG_UP:     seg_up     <= cfg_data[SEG_W-1:0];
        REG_SEG_DEEP:   seg_deep   <= cfg_data[SEG_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective values seen by the generator.
  always_comb begin
    cfg.dim_w = box_width & DIM_MASK;
    cfg.dim_h = box_height & DIM_MASK;
    cfg.dim_d = box_depth & DIM_MASK;
    cfg.seg_a = seg_fix(seg_across);
    cfg.seg_u = seg_fix(seg_up);
    cfg.seg_d = seg_fix(seg_deep);
  end

endmodule

// File: rtl/bmt_divider.sv
// Iterative restoring divider, four quotient bits per cycle, shared by all
// grid divisions of the box mesh tessellator. Depends on bmt_pkg.
module bmt_divider import bmt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [SEG_W-1:0]      divisor,
  output logic                  busy,
  output logic [DIVIDEND_W-1:0] quotient
);

  logic [DIVIDEND_W-1:0] work;
  logic [DIVIDEND_W-1:0] work_next;
  logic [SEG_W-1:0]      rem;
  logic [SEG_W-1:0]      rem_next;
  logic [SEG_W-1:0]      dsr;
  logic [STEP_CNT_W-1:0] count;

  // One digit: shift in dividend bits and subtract where the divisor fits.
  always_comb begin
    logic [SEG_W:0] trial;
    work_next = work;
    rem_next  = rem;
    for (int i = 0; i < DIGIT_BITS; i++) begin
      trial     = {rem_next, work_next[DIVIDEND_W-1]};
      work_next = {work_next[DIVIDEND_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr}) begin
        trial        = trial - {1'b0, dsr};
        work_next[0] = 1'b1;
      end
      rem_next = trial[SEG_W-1:0];
    end
  end

  // Control: busy from a start until the step counter has run down.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= STEP_CNT_W'(QUOT_STEPS - 1);
    end else if (busy) begin
      if (count == '0) begin
        busy <= 1'b0;
      end else begin
        count <= count - STEP_CNT_W'(1);
      end
    end
  end

  // Datapath: the dividend shifts out as the quotient shifts in.
  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
      dsr  <= divisor;
    end else if (busy) begin
      work <= work_next;
      rem  <= rem_next;
    end
  end

  assign quotient = work;

endmodule

// File: rtl/box_mesh_tessellator.sv
// Box mesh tessellator: each command word produces the next vertex or triangle
// word of a segmented six-face box mesh.
//
// Channels: a command word (restart) arrives on cmd_valid/cmd_stall and one
// result word leaves on item_valid/item_stall per command. Configuration is
// written through cfg_write/cfg_index/cfg_data, by the user only while no
// command is in flight; the block does not enforce this. The block takes one
// command at a time and raises cmd_stall until its result has been placed in
// the output register. A vertex word needs four divisions on the shared
// 4-bit-per-cycle divider (two of them preceded by a multiplier step in S_MUL).
// A triangle word uses the shared multiplier twice, in S_TRI1 and S_TRI2.
// The output register lets the next command be taken while a result waits;
// when the receiver stalls, the finished result of that next command waits in
// the sequencer, and item payloads hold steady until taken.
// A synchronous reset returns to face 0, vertex 0, vertex base 0, loads the
// register defaults and clears item_valid.
// Depends on bmt_pkg, bmt_config_regs and bmt_divider.
module box_mesh_tessellator import bmt_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DIM_W-1:0]         cfg_data,
  input  logic                     cmd_valid,
  output logic                     cmd_stall,
  input  logic                     restart,
  output logic                     item_valid,
  input  logic                     item_stall,
  output logic                     is_triangle,
  output logic signed [POS_W-1:0]  pos_x,
  output logic signed [POS_W-1:0]  pos_y,
  output logic signed [POS_W-1:0]  pos_z,
  output logic [TEX_W-1:0]         tex_u,
  output logic [TEX_W-1:0]         tex_v,
  output logic [NORM_W-1:0]        normal_code,
  output logic [IDX_W-1:0]         corner_a,
  output logic [IDX_W-1:0]         corner_b,
  output logic [IDX_W-1:0]         corner_c,
  output logic                     last
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_TRI1  = 3'd4;
  localparam logic [2:0] S_TRI2  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  localparam logic [1:0] OP_POS_U = 2'd0;
  localparam logic [1:0] OP_POS_V = 2'd1;
  localparam logic [1:0] OP_TEX_U = 2'd2;
  localparam logic [1:0] OP_TEX_V = 2'd3;

  localparam int MUL_A_W = SEG_W + 1;
  localparam int MUL_P_W = MUL_A_W + DIM_W;

  bmt_cfg_t cfg;

  logic [2:0] state;
  logic [1:0] op;

  // Generation state.
  logic [FACE_W-1:0] face;
  logic              phase;
  logic [SEG_W-1:0]  row;
  logic [SEG_W-1:0]  col;
  logic              second;
  logic [IDX_W-1:0]  base;

  // Intermediate results.
  logic [MUL_P_W-1:0] prod;
  logic [SEG_W*2+1:0] face_verts;
  logic [POS_W-1:0]   q_u;
  logic [POS_W-1:0]   q_v;
  logic [TEX_W-1:0]   q_tu;
  logic [TEX_W-1:0]   q_tv;

  logic                  div_start;
  logic                  div_busy;
  logic [DIVIDEND_W-1:0] div_dividend;
  logic [SEG_W-1:0]      div_divisor;
  logic [DIVIDEND_W-1:0] div_quot;

  logic [AXIS_W-1:0]  u_ax;
  logic [AXIS_W-1:0]  v_ax;
  logic [AXIS_W-1:0]  w_ax;
  logic [SEG_W-1:0]   sx;
  logic [SEG_W-1:0]   sy;
  logic [SEG_W:0]     sx_p1;
  logic [SEG_W:0]     sy_p1;
  logic [DIM_W-1:0]   dim_u;
  logic [DIM_W-1:0]   dim_v;
  logic [DIM_W-1:0]   dim_w;
  logic [MUL_A_W-1:0] mul_a;
  logic [DIM_W-1:0]   mul_b;
  logic [MUL_P_W-1:0] mul_p;

  logic [POS_W-1:0] pu_raw;
  logic [POS_W-1:0] pv_raw;
  logic [POS_W-1:0] pu;
  logic [POS_W-1:0] pv;
  logic [POS_W-1:0] pw;
  logic [POS_W-1:0] px;
  logic [POS_W-1:0] py;
  logic [POS_W-1:0] pz;

  logic [IDX_W-1:0] ca;
  logic [IDX_W-1:0] cb;
  logic [IDX_W-1:0] cc;
  logic [IDX_W-1:0] cd;
  logic [SEG_W:0]   col_inc;
  logic [SEG_W:0]   row_inc;
  logic             end_face;
  logic             cmd_accept;
  logic             out_load;

  bmt_config_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bmt_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quot)
  );

  // Face geometry of the current face.
  always_comb begin
    u_ax  = face_u_axis(face);
    v_ax  = face_v_axis(face);
    w_ax  = face_w_axis(face);
    sx    = seg_of_axis(cfg, u_ax);
    sy    = seg_of_axis(cfg, v_ax);
    dim_u = dim_of_axis(cfg, u_ax);
    dim_v = dim_of_axis(cfg, v_ax);
    dim_w = dim_of_axis(cfg, w_ax);
    sx_p1 = {1'b0, sx} + (SEG_W+1)'(1);
    sy_p1 = {1'b0, sy} + (SEG_W+1)'(1);
  end

  // Shared multiplier: grid step times extent, then cell and face offsets.
  always_comb begin
    mul_a = {1'b0, op[0] ? row : col};
    mul_b = op[0] ? dim_v : dim_u;
    if (state == S_TRI1) begin
      mul_a = sx_p1;
      mul_b = DIM_W'(row);
    end else if (state == S_TRI2) begin
      mul_a = sx_p1;
      mul_b = DIM_W'(sy_p1);
    end
    mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
  end

  // Divider operands: doubled product for positions, step shifted by 16 for texture.
  always_comb begin
    div_start   = (state == S_START);
    div_divisor = op[0] ? sy : sx;
    if (op[1]) begin
      div_dividend = {4'b0, (op[0] ? row : col), 16'b0};
    end else begin
      div_dividend = {3'b0, prod[23:0], 1'b0};
    end
  end

  // Vertex word: offset by the extent, apply direction signs, map to axes.
  always_comb begin
    pu_raw = q_u - {1'b0, dim_u};
    pv_raw = q_v - {1'b0, dim_v};
    pu     = face_u_neg(face) ? (POS_W'(0) - pu_raw) : pu_raw;
    pv     = face_v_neg(face) ? (POS_W'(0) - pv_raw) : pv_raw;
    pw     = face_w_neg(face) ? (POS_W'(0) - {1'b0, dim_w}) : {1'b0, dim_w};
    px     = (u_ax == AXIS_X) ? pu : (v_ax == AXIS_X) ? pv : pw;
    py     = (u_ax == AXIS_Y) ? pu : (v_ax == AXIS_Y) ? pv : pw;
    pz     = (u_ax == AXIS_Z) ? pu : (v_ax == AXIS_Z) ? pv : pw;
  end

  // Triangle word: corner indexes of the current cell.
  always_comb begin
    ca       = base + IDX_W'(col) + IDX_W'(prod[16:0]);
    cb       = ca + IDX_W'(sx_p1);
    cc       = cb + IDX_W'(1);
    cd       = ca + IDX_W'(1);
    col_inc  = {1'b0, col} + (SEG_W+1)'(1);
    row_inc  = {1'b0, row} + (SEG_W+1)'(1);
    end_face = second && (col_inc >= {1'b0, sx}) && (row_inc >= {1'b0, sy});
  end

  assign cmd_stall  = (state != S_IDLE);
  assign cmd_accept = cmd_valid && !cmd_stall;
  assign out_load   = (state == S_OUT) && (!item_valid || !item_stall);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= OP_POS_U;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_accept) begin
            op <= OP_POS_U;
            if (restart || !phase) begin
              state <= S_MUL;
            end else begin
              state <= S_TRI1;
            end
          end
        end
        S_MUL:   state <= S_START;
        S_START: state <= S_WAIT;
        S_WAIT: begin
          if (!div_busy) begin
            unique case (op)
              OP_POS_U: begin
                op    <= OP_POS_V;
                state <= S_MUL;
              end
              OP_POS_V: begin
                op    <= OP_TEX_U;
                state <= S_START;
              end
              OP_TEX_U: begin
                op    <= OP_TEX_V;
                state <= S_START;
              end
              default:  state <= S_OUT;
            endcase
          end
        end
        S_TRI1:  state <= S_TRI2;
        S_TRI2:  state <= S_OUT;
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Products and quotients.
  always_ff @(posedge clk) begin
    if (state == S_MUL || state == S_TRI1) begin
      prod <= mul_p;
    end
    if (state == S_TRI2) begin
      face_verts <= mul_p[SEG_W*2+1:0];
    end
    if (state == S_WAIT && !div_busy) begin
      unique case (op)
        OP_POS_U: q_u  <= div_quot[POS_W-1:0];
        OP_POS_V: q_v  <= div_quot[POS_W-1:0];
        OP_TEX_U: q_tu <= div_quot[TEX_W-1:0];
        default:  q_tv <= div_quot[TEX_W-1:0];
      endcase
    end
  end

  // Generation state: cleared by restart, advanced when a word is loaded for output.
  always_ff @(posedge clk) begin
    if (rst) begin
      face   <= '0;
      phase  <= 1'b0;
      row    <= '0;
      col    <= '0;
      second <= 1'b0;
      base   <= '0;
    end else if (cmd_accept && restart) begin
      face   <= '0;
      phase  <= 1'b0;
      row    <= '0;
      col    <= '0;
      second <= 1'b0;
      base   <= '0;
    end else if (out_load) begin
      if (!phase) begin
        // Vertex rows run from zero to the segment count inclusive.
        if (col_inc > {1'b0, sx}) begin
          col <= '0;
          if (row_inc > {1'b0, sy}) begin
            row    <= '0;
            phase  <= 1'b1;
            second <= 1'b0;
          end else begin
            row <= row_inc[SEG_W-1:0];
          end
        end else begin
          col <= col_inc[SEG_W-1:0];
        end
      end else if (!second) begin
        second <= 1'b1;
      end else begin
        second <= 1'b0;
        if (col_inc >= {1'b0, sx}) begin
          col <= '0;
          if (row_inc >= {1'b0, sy}) begin
            row   <= '0;
            phase <= 1'b0;
            if (face >= FACE_LAST) begin
              face <= '0;
              base <= '0;
            end else begin
              face <= face + FACE_W'(1);
              base <= base + IDX_W'(face_verts);
            end
          end else begin
            row <= row_inc[SEG_W-1:0];
          end
        end else begin
          col <= col_inc[SEG_W-1:0];
        end
      end
    end
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (out_load) begin
      item_valid <= 1'b1;
    end else if (!item_stall) begin
      item_valid <= 1'b0;
    end
  end

  // Output register payload; fields without meaning for the word are zero.
  always_ff @(posedge clk) begin
    if (out_load) begin
      is_triangle <= phase;
      if (!phase) begin
        pos_x       <= $signed(px);
        pos_y       <= $signed(py);
        pos_z       <= $signed(pz);
        tex_u       <= q_tu;
        tex_v       <= TEX_W'(17'h10000) - q_tv;
        normal_code <= face_normal(face);
        corner_a    <= '0;
        corner_b    <= '0;
        corner_c    <= '0;
        last        <= 1'b0;
      end else begin
        pos_x       <= '0;
        pos_y       <= '0;
        pos_z       <= '0;
        tex_u       <= '0;
        tex_v       <= '0;
        normal_code <= '0;
        corner_a    <= second ? cb : ca;
        corner_b    <= second ? cc : cb;
        corner_c    <= cd;
        last        <= end_face && (face == FACE_LAST);
      end
    end
  end

endmodule

// File: rtl/bmt_checker.sv
// Port-level checker for the box mesh tessellator, attached by a bind below.
// Depends on bmt_pkg for widths and normal codes.
module bmt_checker import bmt_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    cfg_write,
  input logic [CFG_IDX_W-1:0]    cfg_index,
  input logic [DIM_W-1:0]        cfg_data,
  input logic                    cmd_valid,
  input logic                    cmd_stall,
  input logic                    restart,
  input logic                    item_valid,
  input logic                    item_stall,
  input logic                    is_triangle,
  input logic signed [POS_W-1:0] pos_x,
  input logic signed [POS_W-1:0] pos_y,
  input logic signed [POS_W-1:0] pos_z,
  input logic [TEX_W-1:0]        tex_u,
  input logic [TEX_W-1:0]        tex_v,
  input logic [NORM_W-1:0]       normal_code,
  input logic [IDX_W-1:0]        corner_a,
  input logic [IDX_W-1:0]        corner_b,
  input logic [IDX_W-1:0]        corner_c,
  input logic                    last
);

  // A stalled result word holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    item_valid && item_stall |=> item_valid && $stable(is_triangle) &&
      $stable(corner_a) && $stable(pos_x) && $stable(tex_u) && $stable(last))
  else $error("stalled result word changed");

  // The block works on one command at a time.
  assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> cmd_stall)
  else $error("command taken while another is in flight");

  // The end-of-mesh mark only rides on a triangle.
  assert property (@(posedge clk) disable iff (rst)
    item_valid && last |-> is_triangle)
  else $error("end-of-mesh mark on a vertex word");

  // Vertex words carry a valid normal and no corner indexes.
  assert property (@(posedge clk) disable iff (rst)
    item_valid && !is_triangle |-> normal_code <= NORM_NEG_Z &&
      corner_a == '0 && corner_b == '0 && corner_c == '0)
  else $error("malformed vertex word");

  // Triangle words carry no vertex attributes, and the first and third corners differ.
  assert property (@(posedge clk) disable iff (rst)
    item_valid && is_triangle |-> pos_x == '0 && pos_y == '0 && pos_z == '0 &&
      tex_u == '0 && tex_v == '0 && normal_code == '0 && corner_c != corner_a)
  else $error("malformed triangle word");

endmodule

bind box_mesh_tessellator bmt_checker u_bmt_checker (.*);

// File: dv/tb_box_mesh_tessellator.sv
// Self-checking testbench for box_mesh_tessellator: command words go in, vertex and
// triangle words come out and are compared with a built-in mesh predictor.
// Depends on bmt_pkg and the box_mesh_tessellator RTL.
module tb_box_mesh_tessellator;
  timeunit 1ns;
  timeprecision 1ps;
  import bmt_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 60;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_WORDS   = 150;
  localparam longint TEX_ONE   = 65536;

  // Per-face axis mapping, direction signs and normals, indexed by face number.
  localparam logic [5:0][AXIS_W-1:0] FACE_U = {AXIS_Z, AXIS_Z, AXIS_X, AXIS_X, AXIS_X, AXIS_X};
  localparam logic [5:0][AXIS_W-1:0] FACE_V = {AXIS_Y, AXIS_Y, AXIS_Z, AXIS_Z, AXIS_Y, AXIS_Y};
  localparam logic [5:0][AXIS_W-1:0] FACE_W = {AXIS_X, AXIS_X, AXIS_Y, AXIS_Y, AXIS_Z, AXIS_Z};
  localparam logic [5:0] U_NEG = 6'b010010;
  localparam logic [5:0] V_NEG = 6'b111011;
  localparam logic [5:0] W_NEG = 6'b101010;
  localparam logic [5:0][NORM_W-1:0] NORMALS = {NORM_NEG_X, NORM_POS_X, NORM_NEG_Y,
                                                NORM_POS_Y, NORM_NEG_Z, NORM_POS_Z};

  typedef struct packed {
    logic             is_tri;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [POS_W-1:0] pos_z;
    logic [TEX_W-1:0] tex_u;
    logic [TEX_W-1:0] tex_v;
    logic [NORM_W-1:0] norm;
    logic [IDX_W-1:0] ca;
    logic [IDX_W-1:0] cb;
    logic [IDX_W-1:0] cc;
    logic             last_tri;
  } mesh_word_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = REG_BOX_WIDTH;
  logic [DIM_W-1:0]        cfg_data = '0;
  logic                    cmd_valid = 1'b0;
  logic                    cmd_stall;
  logic                    restart = 1'b0;
  logic                    item_valid;
  logic                    item_stall = 1'b0;
  logic                    is_triangle;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic [TEX_W-1:0]        tex_u;
  logic [TEX_W-1:0]        tex_v;
  logic [NORM_W-1:0]       normal_code;
  logic [IDX_W-1:0]        corner_a;
  logic [IDX_W-1:0]        corner_b;
  logic [IDX_W-1:0]        corner_c;
  logic                    last;

  // Predictor copy of the configuration, indexed by axis.
  logic [DIM_W-1:0] ext_cfg [3] = '{16'd256, 16'd256, 16'd256};
  logic [SEG_W-1:0] seg_cfg [3] = '{8'd1, 8'd1, 8'd1};

  // Predictor copy of the sequencer position.
  int               mesh_face = 0;
  logic             in_tri_phase = 1'b0;
  int               grid_r = 0;
  int               grid_c = 0;
  logic             upper_tri = 1'b0;
  logic [IDX_W-1:0] vert_base = '0;

  mesh_word_t pending_words [$];
  bit         idle_on = 1'b1;
  int         hold_seq = 0;
  int         hold_seen = 0;
  int         hold_left = 0;
  int         stall_left = 0;
  int         words_sent = 0;
  int         words_checked = 0;
  int         meshes_done = 0;
  int         settings_used = 0;
  int         mismatch_count = 0;
  int         cycle_count = 0;

  box_mesh_tessellator i_dut (.*);

  initial forever #5 clk = ~clk;

  // Guard against a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Segment count as the block uses it: zero acts as one, large counts clamp.
  function automatic longint eff_seg(input logic [AXIS_W-1:0] axis);
    longint s;
    s = longint'(seg_cfg[axis]);
    if (s == 0) s = 1;
    if (s > SEG_MAX) s = SEG_MAX;
    return s;
  endfunction

  // Grid coordinate in half units: trunc(2*k*dim/seg) - dim, optionally negated.
  function automatic logic [POS_W-1:0] grid_coord(input longint k, input longint dim,
                                                  input longint seg, input logic neg);
    longint v;
    v = (2 * k * dim) / seg - dim;
    if (neg) v = -v;
    return POS_W'(v);
  endfunction

  // Works out the word that the next command produces and advances the position.
  function automatic mesh_word_t next_mesh_word(input logic rs);
    mesh_word_t w;
    int f;
    logic [AXIS_W-1:0] ua, va, wa;
    longint sx, sy, a, b, c, d;
    logic [POS_W-1:0] pos [3];
    logic end_face;
    w = '0;
    if (rs) begin
      mesh_face = 0;
      in_tri_phase = 1'b0;
      grid_r = 0;
      grid_c = 0;
      upper_tri = 1'b0;
      vert_base = '0;
    end
    if (mesh_face > FACE_LAST) mesh_face = 0;
    f = mesh_face;
    ua = FACE_U[f];
    va = FACE_V[f];
    wa = FACE_W[f];
    sx = eff_seg(ua);
    sy = eff_seg(va);
    if (!in_tri_phase) begin
      // Vertex of the face grid, row by row.
      pos[ua] = grid_coord(grid_c, longint'(ext_cfg[ua]), sx, U_NEG[f]);
      pos[va] = grid_coord(grid_r, longint'(ext_cfg[va]), sy, V_NEG[f]);
      pos[wa] = POS_W'(W_NEG[f] ? -longint'(ext_cfg[wa]) : longint'(ext_cfg[wa]));
      w.pos_x = pos[AXIS_X];
      w.pos_y = pos[AXIS_Y];
      w.pos_z = pos[AXIS_Z];
      w.tex_u = TEX_W'((longint'(grid_c) * TEX_ONE) / sx);
      w.tex_v = TEX_W'(TEX_ONE - (longint'(grid_r) * TEX_ONE) / sy);
      w.norm = NORMALS[f];
      grid_c++;
      if (grid_c > sx) begin
        grid_c = 0;
        grid_r++;
        if (grid_r > sy) begin
          grid_r = 0;
          in_tri_phase = 1'b1;
          upper_tri = 1'b0;
        end
      end
    end else begin
      // Two triangles per cell; the second one closes the cell.
      a = longint'(vert_base) + grid_c + (sx + 1) * grid_r;
      b = a + sx + 1;
      c = b + 1;
      d = a + 1;
      end_face = upper_tri && (grid_c + 1 >= sx) && (grid_r + 1 >= sy);
      w.is_tri = 1'b1;
      w.ca = IDX_W'(upper_tri ? b : a);
      w.cb = IDX_W'(upper_tri ? c : b);
      w.cc = IDX_W'(d);
      w.last_tri = end_face && (f == FACE_LAST);
      if (!upper_tri) begin
        upper_tri = 1'b1;
      end else begin
        upper_tri = 1'b0;
        grid_c++;
        if (grid_c >= sx) begin
          grid_c = 0;
          grid_r++;
          if (grid_r >= sy) begin
            grid_r = 0;
            in_tri_phase = 1'b0;
            vert_base = IDX_W'(longint'(vert_base) + (sx + 1) * (sy + 1));
            mesh_face++;
            if (mesh_face > FACE_LAST) begin
              mesh_face = 0;
              vert_base = '0;
            end
          end
        end
      end
    end
    return w;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                 input logic [31:0] want_v);
    $display("mismatch on %s at word %0d: got %0h, wanted %0h",
             what, words_checked, got_v, want_v);
    mismatch_count++;
  endtask

  // Receiver: random stall after each taken word while idle_on is set, plus a long hold-off on request.
  always @(posedge clk) begin : drive_item_stall
    logic nxt;
    nxt = 1'b0;
    if (rst) begin
      hold_left = 0;
      stall_left = 0;
    end else begin
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (item_valid && !item_stall) stall_left = idle_on ? $urandom_range(0, 6) : 0;
      if (hold_left > 0) begin
        nxt = 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        nxt = 1'b1;
        stall_left--;
      end
    end
    item_stall <= nxt;
  end

  // Compare every taken word with the oldest pending prediction.
  always @(posedge clk) begin : check_words
    mesh_word_t want, got;
    if (!rst && item_valid && !item_stall) begin
      got = {is_triangle, pos_x, pos_y, pos_z, tex_u, tex_v, normal_code,
             corner_a, corner_b, corner_c, last};
      if (pending_words.size() == 0) begin
        report_mismatch("word with nothing pending", 32'(got.is_tri), 32'd0);
      end else begin
        want = pending_words.pop_front();
        if (got.is_tri !== want.is_tri)
          report_mismatch("is_triangle", 32'(got.is_tri), 32'(want.is_tri));
        if (got.pos_x !== want.pos_x)
          report_mismatch("pos_x", 32'(got.pos_x), 32'(want.pos_x));
        if (got.pos_y !== want.pos_y)
          report_mismatch("pos_y", 32'(got.pos_y), 32'(want.pos_y));
        if (got.pos_z !== want.pos_z)
          report_mismatch("pos_z", 32'(got.pos_z), 32'(want.pos_z));
        if (got.tex_u !== want.tex_u)
          report_mismatch("tex_u", 32'(got.tex_u), 32'(want.tex_u));
        if (got.tex_v !== want.tex_v)
          report_mismatch("tex_v", 32'(got.tex_v), 32'(want.tex_v));
        if (got.norm !== want.norm)
          report_mismatch("normal_code", 32'(got.norm), 32'(want.norm));
        if (got.ca !== want.ca)
          report_mismatch("corner_a", 32'(got.ca), 32'(want.ca));
        if (got.cb !== want.cb)
          report_mismatch("corner_b", 32'(got.cb), 32'(want.cb));
        if (got.cc !== want.cc)
          report_mismatch("corner_c", 32'(got.cc), 32'(want.cc));
        if (got.last_tri !== want.last_tri)
          report_mismatch("last", 32'(got.last_tri), 32'(want.last_tri));
        if (want.last_tri) meshes_done++;
        words_checked++;
      end
    end
  end

  // Offers one command word after a random gap (none while idle_on is clear) and waits until it is taken.
  task automatic push_command(input logic rs);
    int gap;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    if (gap != 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    restart   <= rs;
    do @(posedge clk); while (cmd_stall);
    pending_words.insert(pending_words.size(), next_mesh_word(rs));
    words_sent++;
  endtask

  // Stops offering commands and waits until every predicted word has arrived.
  task automatic wait_mesh_drained();
    if (cmd_valid) cmd_valid <= 1'b0;
    if (pending_words.size() != 0) begin
      while (pending_words.size() != 0) @(negedge clk);
      @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_BOX_WIDTH:  ext_cfg[AXIS_X] = val;
      REG_BOX_HEIGHT: ext_cfg[AXIS_Y] = val;
      REG_BOX_DEPTH:  ext_cfg[AXIS_Z] = val;
      REG_SEG_ACROSS: seg_cfg[AXIS_X] = val[SEG_W-1:0];
      REG_SEG_UP:     seg_cfg[AXIS_Y] = val[SEG_W-1:0];
      REG_SEG_DEEP:   seg_cfg[AXIS_Z] = val[SEG_W-1:0];
      default: ;
    endcase
  endtask

  // Writes all six registers back to back; only called while the block is idle.
  task automatic load_box(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                          input logic [DIM_W-1:0] d, input logic [DIM_W-1:0] sa,
                          input logic [DIM_W-1:0] su, input logic [DIM_W-1:0] sd);
    write_reg(REG_BOX_WIDTH, w);
    write_reg(REG_BOX_HEIGHT, h);
    write_reg(REG_BOX_DEPTH, d);
    write_reg(REG_SEG_ACROSS, sa);
    write_reg(REG_SEG_UP, su);
    write_reg(REG_SEG_DEEP, sd);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  // Extent with the zero, one and full-scale cases weighted up.
  function automatic logic [DIM_W-1:0] pick_extent();
    logic [DIM_W-1:0] v;
    case ($urandom_range(0, 7))
      0:       v = '0;
      1:       v = DIM_W'(1);
      2:       v = '1;
      default: v = DIM_W'($urandom_range(1, 65535));
    endcase
    return v;
  endfunction

  // Segment count, mostly small so meshes complete; junk in the upper byte.
  function automatic logic [DIM_W-1:0] pick_segments();
    logic [SEG_W-1:0] s;
    case ($urandom_range(0, 15))
      0:       s = '0;
      1:       s = SEG_W'($urandom_range(4, 255));
      default: s = SEG_W'($urandom_range(1, 3));
    endcase
    return {8'($urandom_range(0, 255)), s};
  endfunction

  // Default registers straight out of reset: first face and the start of the next.
  task automatic test_power_on_mesh();
    repeat (8) push_command(1'b0);
  endtask

  // Full-scale and zero extents, a masked-to-zero count and the largest count.
  task automatic test_field_extremes();
    wait_mesh_drained();
    load_box(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0100, 16'h00FF, 16'h0001);
    push_command(1'b1);
    repeat (5) push_command(1'b0);
  endtask

  // The up count shrinks under a mesh in progress; the row runs past the new count.
  task automatic test_midmesh_reconfig();
    wait_mesh_drained();
    load_box(16'h0003, 16'hFFFF, 16'h0001, 16'h0002, 16'h0001, 16'h0001);
    repeat (6) push_command(1'b0);
  endtask

  // Receiver holds off while commands keep coming, then the sender waits it out.
  task automatic test_backpressure();
    wait_mesh_drained();
    idle_on  <= 1'b0;
    hold_seq <= hold_seq + 1;
    repeat (12) push_command(1'b0);
    wait_mesh_drained();
    idle_on <= 1'b1;
    repeat (10) push_command(1'b0);
  endtask

  // Meshes under a series of settings, each begun by a restart, with occasional further restarts.
  task automatic test_random_meshes();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_mesh_drained();
      case (phase)
        0: load_box(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
        1: load_box(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd255, 16'd255, 16'd255);
        2: load_box(16'd0, 16'd0, 16'd0, 16'h0000, 16'hFF00, 16'h0000);
        default: load_box(pick_extent(), pick_extent(), pick_extent(),
                          pick_segments(), pick_segments(), pick_segments());
      endcase
      idle_on <= (phase % 3 != 1);
      push_command(1'b1);
      repeat (PHASE_WORDS - 1) push_command($urandom_range(0, 99) < 3);
    end
  endtask

  task automatic finish_run();
    wait_mesh_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d command words and checked %0d result words (%0d complete meshes).",
             words_sent, words_checked, meshes_done);
    $display("Ran %0d box settings, a %0d-cycle output hold-off and %0d mismatches.",
             settings_used, HOLD_CYCLES, mismatch_count);
    if (mismatch_count == 0 && pending_words.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_power_on_mesh();
    test_field_extremes();
    test_midmesh_reconfig();
    test_backpressure();
    test_random_meshes();
    finish_run();
  end

endmodule

// File: sim.f
rtl/bmt_pkg.sv
rtl/bmt_config_regs.sv
rtl/bmt_divider.sv
rtl/box_mesh_tessellator.sv
rtl/bmt_checker.sv
dv/tb_box_mesh_tessellator.sv
